[design/spl_pkg.sv]
// Shared types, constants and terrain tables for the SUI path loss pipeline.
package spl_pkg;

  localparam int FREQ_W = 14;
  localparam int HT_W   = 16;
  localparam int DIST_W = 20;
  localparam int TC_W   = 2;
  localparam int LOSS_W = 16;
  localparam int ST_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [FREQ_W-1:0] FREQ_RST = 14'd3500;
  localparam logic [HT_W-1:0]   TXH_RST  = 16'd3000;
  localparam logic [TC_W-1:0]   TERR_RST = 2'd1;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 14'd1900;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 14'd11000;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FREQ = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

  localparam int LOSS_FRAC_BITS = 6;
  localparam int RND_SH         = 24 - LOSS_FRAC_BITS;

  // log unit
  localparam int LOG_IN_W   = 20;
  localparam int LOG_TOP_W  = 5;
  localparam int LOG_FRAC_W = 24;
  localparam int LOG_LG_W   = LOG_TOP_W + LOG_FRAC_W;
  localparam int LOG_OUT_W  = 27;
  localparam int LOG_LAT    = LOG_FRAC_W + 3;
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

  // divider
  localparam int DIV_NUM_W = 40;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // b*ht*2^16/100000 = floor(n/3125)*2048 + floor(rem*2048/3125)
  localparam logic [11:0] B_DIV = 12'd3125;
  localparam logic [22:0] B_M1  = 23'd5497559;    // ceil(2^34/3125)
  localparam logic [23:0] B_M2  = 24'd10995117;   // ceil(2^35/3125)

  localparam int LOG_PAD = DIV_LAT - LOG_LAT;
  localparam int TOT_W   = 48;

  localparam logic [27:0] D_OFS = 28'd33554432;   // 2.0 in Q24
  localparam logic [27:0] H_OFS = 28'd38604877;   // 2.0 + log10(2) in Q24
  // 20*log10(4pi/3) - 18 - 6*log10(2), Q24
  localparam logic signed [TOT_W-1:0] TF_OFS = -48'sd123554258;
  localparam logic [31:0] DIV10_M = 32'hCCCCCCCD;

  localparam logic [1:0] TER_A = 2'd0;
  localparam logic [1:0] TER_B = 2'd1;
  localparam logic [1:0] TER_C = 2'd2;

  function automatic logic [1:0] ter_idx(input logic [TC_W-1:0] tc);
    logic [1:0] t;
    unique case (tc)
      2'd2:    t = TER_B;
      2'd3:    t = TER_C;
      default: t = TER_A;
    endcase
    return t;
  endfunction

  function automatic logic [21:0] a10_q16(input logic [1:0] t);
    logic [21:0] v;
    unique case (t)
      TER_B:   v = 22'd2621440;
      TER_C:   v = 22'd2359296;
      default: v = 22'd3014656;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] b5_val(input logic [1:0] t);
    logic [6:0] v;
    unique case (t)
      TER_B:   v = 7'd65;
      TER_C:   v = 7'd50;
      default: v = 7'd75;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] c_q16(input logic [1:0] t);
    logic [30:0] v;
    unique case (t)
      TER_B:   v = 31'd1120665600;
      TER_C:   v = 31'd1310720000;
      default: v = 31'd825753600;
    endcase
    return v;
  endfunction

  function automatic logic [27:0] s_q24(input logic [1:0] t);
    logic [27:0] v;
    unique case (t)
      TER_B:   v = 28'd100663296;
      TER_C:   v = 28'd50331648;
      default: v = 28'd177838490;
    endcase
    return v;
  endfunction

endpackage

[design/spl_log10.sv]
// Pipelined log10 in Q24: normalize, 24 squaring stages, scale and round.
module spl_log10 (
  input  logic                           clk,
  input  logic                           en,
  input  logic [spl_pkg::LOG_IN_W-1:0]   x,
  output logic [spl_pkg::LOG_OUT_W-1:0]  l10
);

  localparam int NF = spl_pkg::LOG_FRAC_W;

  logic [31:0]                    m_r    [0:NF];
  logic [spl_pkg::LOG_TOP_W-1:0]  top_r  [0:NF];
  logic [NF-1:0]                  frac_r [0:NF];
  logic [63:0]                    sq     [1:NF];

  logic [spl_pkg::LOG_TOP_W-1:0]  top_nxt;
  logic [31:0]                    m_nxt;
  logic [spl_pkg::LOG_LG_W-1:0]   lg;
  logic [59:0]                    prod_r;
  logic [59:0]                    rnd;
  logic [spl_pkg::LOG_OUT_W-1:0]  l10_r;

  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < spl_pkg::LOG_IN_W; i++) begin
      if (x[i]) top_nxt = spl_pkg::LOG_TOP_W'(i);
    end
    m_nxt = 32'(x) << (5'd31 - top_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m_nxt;
      top_r[0]  <= top_nxt;
      frac_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NF; k++) begin : g_sq
    assign sq[k] = 64'(m_r[k-1]) * 64'(m_r[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]    <= sq[k][63] ? sq[k][63:32] : sq[k][62:31];
        top_r[k]  <= top_r[k-1];
        frac_r[k] <= {frac_r[k-1][NF-2:0], sq[k][63]};
      end
    end
  end

  assign lg  = {top_r[NF], frac_r[NF]};
  assign rnd = prod_r + 60'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 60'(lg) * 60'(spl_pkg::LOG10_2_Q32);
      l10_r  <= rnd[58:32];
    end
  end

  assign l10 = l10_r;

endmodule

[design/spl_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module spl_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [spl_pkg::DIV_NUM_W-1:0]   num,
  input  logic [spl_pkg::DIV_DEN_W-1:0]   den,
  output logic [spl_pkg::DIV_Q_W-1:0]     q
);

  localparam int NQ = spl_pkg::DIV_Q_W;
  localparam int DW = spl_pkg::DIV_DEN_W;

  logic [DW-1:0] rem_r [0:NQ];
  logic [NQ-1:0] low_r [0:NQ];
  logic [DW-1:0] den_r [0:NQ];
  logic [NQ-1:0] q_r   [0:NQ];
  logic [DW:0]   rem2  [1:NQ];
  logic [DW:0]   diff  [1:NQ];
  logic          ge    [1:NQ];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num[spl_pkg::DIV_NUM_W-1:NQ]);
      low_r[0] <= num[NQ-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_st
    assign rem2[k] = {rem_r[k-1], low_r[k-1][NQ-1]};
    assign diff[k] = rem2[k] - {1'b0, den_r[k-1]};
    assign ge[k]   = rem2[k] >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge[k] ? diff[k][DW-1:0] : rem2[k][DW-1:0];
        low_r[k] <= low_r[k-1] << 1;
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][NQ-2:0], ge[k]};
      end
    end
  end

  assign q = q_r[NQ];

endmodule

[design/sui_path_loss.sv]
// SUI path loss: config registers, log and divider units, term sum, rounding.
// Throughput: one transaction per cycle unless stalled; log and divider fully pipelined.
// A stalled output freezes all stages but the b-term ones; nothing is dropped or repeated.
// Reset: rst_n synchronous active low clears valid bits and loads config defaults.
module sui_path_loss (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spl_pkg::HT_W-1:0]         in_rx_height_cm,
  input  logic [spl_pkg::DIST_W-1:0]       in_distance_m,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [spl_pkg::LOSS_W-1:0] out_loss_db,
  output logic [spl_pkg::ST_W-1:0]         out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NCH = spl_pkg::DIV_LAT + 4;
  localparam int TW  = spl_pkg::TOT_W;
  localparam int OW  = spl_pkg::LOG_OUT_W;

  logic [spl_pkg::FREQ_W-1:0] freq_r;
  logic [spl_pkg::HT_W-1:0]   txh_r;
  logic [spl_pkg::TC_W-1:0]   terr_r;
  logic [1:0]                 ter;

  logic en;
  logic [spl_pkg::ST_W-1:0] st_in;

  logic                     vld_r [1:NCH];
  logic [spl_pkg::ST_W-1:0] st_r  [1:NCH];

  logic [OW-1:0] lf, ld, lh;
  logic [OW-1:0] lf_dly_r [0:spl_pkg::LOG_PAD-1];
  logic [OW-1:0] ld_dly_r [0:spl_pkg::LOG_PAD-1];
  logic [OW-1:0] lh_dly_r [0:spl_pkg::LOG_PAD-1];

  logic [22:0]                    b5ht;
  logic [spl_pkg::DIV_NUM_W-1:0]  numc;
  logic [spl_pkg::DIV_Q_W-1:0]    qc;

  // b term, from config only; settles through bn_r, ba_r, br_r and qb_r after a config write
  logic [22:0]                    bn_r, bn2_r, bsub;
  logic [45:0]                    bprod;
  logic [10:0]                    ba_r, ba2_r;
  logic [11:0]                    br_r;
  logic [46:0]                    bfprod;
  logic [spl_pkg::DIV_Q_W-1:0]    qb_r;

  // stage A
  logic signed [32:0]   y10_nxt, y10_r;
  logic signed [27:0]   xd_nxt, xd_r;
  logic signed [27:0]   xh;
  logic [26:0]          xn_nxt, xn_r, xn_b_r;
  logic                 xpos_nxt, xpos_r, xpos_b_r;
  logic signed [TW-1:0] tf_nxt, tf_r, tf_b_r, tf_c_r;
  // stage B
  logic signed [60:0]   pd_nxt, pd_r;
  logic [31:0]          ydiv;
  logic [63:0]          mprod;
  logic [28:0]          qy_r;
  // stage C
  logic [60:0]          pmag;
  logic [60:0]          pq_full;
  logic [44:0]          pq;
  logic [31:0]          xq;
  logic signed [TW-1:0] dterm_nxt, dterm_r, xterm_nxt, xterm_r;
  // stage D
  logic signed [TW-1:0] total_nxt, total_r;
  // output
  logic [TW-1:0]        tmag, rsum, rr;
  logic [spl_pkg::LOSS_W-1:0] sat;

  logic                           out_valid_r;
  logic [spl_pkg::LOSS_W-1:0]     out_loss_r;
  logic [spl_pkg::ST_W-1:0]       out_status_r;

  assign ter       = spl_pkg::ter_idx(terr_r);
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= spl_pkg::FREQ_RST;
      txh_r  <= spl_pkg::TXH_RST;
      terr_r <= spl_pkg::TERR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spl_pkg::CFG_FREQ: freq_r <= cfg_data[spl_pkg::FREQ_W-1:0];
        spl_pkg::CFG_TXH:  txh_r  <= cfg_data[spl_pkg::HT_W-1:0];
        spl_pkg::CFG_TERR: terr_r <= cfg_data[spl_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (freq_r < spl_pkg::FREQ_MIN || freq_r > spl_pkg::FREQ_MAX) begin
      st_in = spl_pkg::ST_FREQ;
    end else if (txh_r == '0 || in_rx_height_cm == '0 || in_distance_m == '0) begin
      st_in = spl_pkg::ST_ZERO;
    end else begin
      st_in = spl_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NCH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int i = 2; i <= NCH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= st_in;
      for (int i = 2; i <= NCH; i++) st_r[i] <= st_r[i-1];
    end
  end

  spl_log10 u_log_f (
    .clk (clk), .en (en),
    .x   (spl_pkg::LOG_IN_W'(freq_r)),
    .l10 (lf)
  );

  spl_log10 u_log_d (
    .clk (clk), .en (en),
    .x   (spl_pkg::LOG_IN_W'(in_distance_m)),
    .l10 (ld)
  );

  spl_log10 u_log_h (
    .clk (clk), .en (en),
    .x   (spl_pkg::LOG_IN_W'(in_rx_height_cm)),
    .l10 (lh)
  );

  assign b5ht   = 23'(spl_pkg::b5_val(ter)) * 23'(txh_r);
  assign bprod  = 46'(bn_r) * 46'(spl_pkg::B_M1);
  assign bsub   = bn2_r - 23'(ba_r) * 23'(spl_pkg::B_DIV);
  assign bfprod = 47'({br_r, 11'd0}) * 47'(spl_pkg::B_M2);

  always_ff @(posedge clk) begin
    bn_r  <= b5ht;
    ba_r  <= bprod[44:34];
    bn2_r <= bn_r;
    br_r  <= bsub[11:0];
    ba2_r <= ba_r;
    qb_r  <= spl_pkg::DIV_Q_W'({ba2_r, bfprod[45:35]});
  end

  assign numc = spl_pkg::DIV_NUM_W'(spl_pkg::c_q16(ter));

  spl_div u_div_c (
    .clk (clk), .en (en),
    .num (numc),
    .den (spl_pkg::DIV_DEN_W'(txh_r)),
    .q   (qc)
  );

  // log results wait for the divider quotient
  always_ff @(posedge clk) begin
    if (en) begin
      lf_dly_r[0] <= lf;
      ld_dly_r[0] <= ld;
      lh_dly_r[0] <= lh;
      for (int i = 1; i < spl_pkg::LOG_PAD; i++) begin
        lf_dly_r[i] <= lf_dly_r[i-1];
        ld_dly_r[i] <= ld_dly_r[i-1];
        lh_dly_r[i] <= lh_dly_r[i-1];
      end
    end
  end

  // stage A: gamma*10 in Q16, log offsets, frequency terms
  always_comb begin
    y10_nxt  = 33'(spl_pkg::a10_q16(ter)) - 33'(qb_r) + 33'(qc);
    xd_nxt   = 28'({1'b0, ld_dly_r[spl_pkg::LOG_PAD-1]}) - spl_pkg::D_OFS;
    xh       = 28'({1'b0, lh_dly_r[spl_pkg::LOG_PAD-1]}) - spl_pkg::H_OFS;
    xn_nxt   = xh[27] ? 27'(-xh) : xh[26:0];
    xpos_nxt = !xh[27];
    tf_nxt   = $signed(TW'(lf_dly_r[spl_pkg::LOG_PAD-1]) * TW'(26)) + spl_pkg::TF_OFS;
  end

  // stage B: distance product, height term divide by ten
  assign pd_nxt = y10_r * xd_r;
  assign ydiv   = {2'b00, xn_r, 3'b000} + 32'd5;
  assign mprod  = 64'(ydiv) * 64'(spl_pkg::DIV10_M);

  // stage C: round halves away from zero
  always_comb begin
    pmag    = pd_r[60] ? 61'(-pd_r) : 61'(pd_r);
    pq_full = (pmag + 61'd32768) >> 16;
    pq      = pq_full[44:0];
    dterm_nxt = pd_r[60] ? -TW'(pq) : TW'(pq);
    if (ter == spl_pkg::TER_C) begin
      xq = 32'(xn_b_r) * 32'd20;
    end else begin
      xq = 32'(xn_b_r) * 32'd10 + 32'(qy_r);
    end
    xterm_nxt = xpos_b_r ? -TW'(xq) : TW'(xq);
  end

  assign total_nxt = tf_c_r + dterm_r + xterm_r + TW'(spl_pkg::s_q24(ter));

  always_ff @(posedge clk) begin
    if (en) begin
      y10_r    <= y10_nxt;
      xd_r     <= xd_nxt;
      xn_r     <= xn_nxt;
      xpos_r   <= xpos_nxt;
      tf_r     <= tf_nxt;
      pd_r     <= pd_nxt;
      qy_r     <= mprod[63:35];
      xn_b_r   <= xn_r;
      xpos_b_r <= xpos_r;
      tf_b_r   <= tf_r;
      dterm_r  <= dterm_nxt;
      xterm_r  <= xterm_nxt;
      tf_c_r   <= tf_b_r;
      total_r  <= total_nxt;
    end
  end

  // final rounding to output step and saturation
  always_comb begin
    tmag = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
    rsum = tmag + (TW'(1) << (spl_pkg::RND_SH - 1));
    rr   = rsum >> spl_pkg::RND_SH;
    if (total_r[TW-1]) begin
      if (rr > TW'(32768)) sat = 16'h8000;
      else                 sat = 16'(-rr);
    end else begin
      if (rr > TW'(32767)) sat = 16'h7FFF;
      else                 sat = rr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NCH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= st_r[NCH];
      out_loss_r   <= (st_r[NCH] == spl_pkg::ST_OK) ? sat : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_loss_db = $signed(out_loss_r);

endmodule
